FILE: hw/rtl/mu8v_pkg.sv
`default_nettype none
package mu8v_pkg;

	// one-hot decoder state
	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_NUL2    = 9'b000000010,
		PH_CONT1   = 9'b000000100,
		PH_E0      = 9'b000001000,
		PH_CONT2   = 9'b000010000,
		PH_ED      = 9'b000100000,
		PH_HI3     = 9'b001000000,
		PH_LO_LEAD = 9'b010000000,
		PH_LO_2    = 9'b100000000
	} phase_t;

	typedef struct packed {
		phase_t next_phase;
		logic   err;
	} step_t;

	localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
	localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
	localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
	localparam logic [7:0] BYTE_NUL_LEAD = 8'hC0;
	localparam logic [7:0] BYTE_2B_LO    = 8'hC2;
	localparam logic [7:0] BYTE_2B_HI    = 8'hDF;
	localparam logic [7:0] BYTE_E0       = 8'hE0;
	localparam logic [7:0] BYTE_3B_HI    = 8'hEF;
	localparam logic [7:0] BYTE_ED       = 8'hED;
	localparam logic [7:0] BYTE_SURR_LO  = 8'hA0;
	localparam logic [7:0] BYTE_ED_LO_HI = 8'h9F;
	localparam logic [7:0] BYTE_HI_SURR  = 8'hAF;
	localparam logic [7:0] BYTE_LO_SURR  = 8'hB0;

endpackage
`default_nettype wire

FILE: hw/rtl/mu8v_decode.sv
`default_nettype none
module mu8v_decode
	import mu8v_pkg::*;
(
	input  var phase_t     phase,
	input  var logic [7:0] data,
	output var step_t      step
);

	logic is_cont;
	logic is_ascii;

	assign is_cont  = (data >= BYTE_CONT_LO) && (data <= BYTE_CONT_HI);
	assign is_ascii = (data != 8'h00) && (data <= BYTE_ASCII_HI);

	always_comb begin
		step.next_phase = PH_IDLE;
		step.err        = 1'b0;
		unique case (phase)
			PH_IDLE: begin
				if (is_ascii) begin
					step.next_phase = PH_IDLE;
				end else if (data == BYTE_NUL_LEAD) begin
					step.next_phase = PH_NUL2;
				end else if ((data >= BYTE_2B_LO) && (data <= BYTE_2B_HI)) begin
					step.next_phase = PH_CONT1;
				end else if (data == BYTE_E0) begin
					step.next_phase = PH_E0;
				end else if (data == BYTE_ED) begin
					step.next_phase = PH_ED;
				end else if ((data > BYTE_E0) && (data <= BYTE_3B_HI)) begin
					step.next_phase = PH_CONT2;
				end else begin
					step.err = 1'b1;
				end
			end
			PH_NUL2: begin
				step.err = (data != BYTE_CONT_LO);
			end
			PH_CONT1: begin
				step.err = !is_cont;
			end
			PH_E0: begin
				step.next_phase = PH_CONT1;
				step.err = !((data >= BYTE_SURR_LO) && (data <= BYTE_CONT_HI));
			end
			PH_CONT2: begin
				step.next_phase = PH_CONT1;
				step.err        = !is_cont;
			end
			PH_ED: begin
				if ((data >= BYTE_CONT_LO) && (data <= BYTE_ED_LO_HI)) begin
					step.next_phase = PH_CONT1;
				end else if ((data >= BYTE_SURR_LO) && (data <= BYTE_HI_SURR)) begin
					step.next_phase = PH_HI3;
				end else begin
					step.err = 1'b1;
				end
			end
			PH_HI3: begin
				step.next_phase = PH_LO_LEAD;
				step.err        = !is_cont;
			end
			PH_LO_LEAD: begin
				step.next_phase = PH_LO_2;
				step.err        = (data != BYTE_ED);
			end
			PH_LO_2: begin
				step.next_phase = PH_CONT1;
				step.err = !((data >= BYTE_LO_SURR) && (data <= BYTE_CONT_HI));
			end
			default: begin
				step.err = 1'b1;
			end
		endcase
		// an error drops back to lead-byte state
		if (step.err) begin
			step.next_phase = PH_IDLE;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/modified_utf8_validator_top.sv
`default_nettype none
// a last byte's verdict reaches result_valid through the input register and then the result register
// throughput: one byte per cycle while data_stall is low; input register, decode, then one result register
// input stalls only while a last beat sits in the input register behind a stalled result
// reset: asynchronous active-low arst_n clears the stage valid, decoder state,
// sticky error and result valid; the block then expects the lead byte of a new string
module modified_utf8_validator_top
	import mu8v_pkg::*;
(
	input  var logic       clk,
	input  var logic       arst_n,
	input  var logic       data_valid,
	output var logic       data_stall,
	input  var logic [7:0] data_byte,
	input  var logic       last_byte,
	output var logic       result_valid,
	input  var logic       result_stall,
	output var logic       string_valid
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	phase_t     phase_q;
	logic       err_q;
	logic       string_valid_q;
	logic       result_valid_q;
	step_t      step;
	logic       adv_s1;
	logic       fire_s1;
	logic       in_take;
	logic       err_any;

	mu8v_decode u_decode (
		.phase (phase_q),
		.data  (byte_s1),
		.step  (step)
	);

	// a last beat can only leave stage 1 when the result slot frees up
	assign adv_s1     = !(last_s1 && result_valid_q && result_stall);
	assign fire_s1    = valid_s1 && adv_s1;
	assign data_stall = valid_s1 && !adv_s1;
	assign in_take    = data_valid && !data_stall;
	assign err_any    = err_q || step.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			err_q   <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				phase_q <= PH_IDLE;
				err_q   <= 1'b0;
			end else begin
				phase_q <= step.next_phase;
				err_q   <= err_any;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			string_valid_q <= !err_any && (step.next_phase == PH_IDLE);
		end
	end

	assign result_valid = result_valid_q;
	assign string_valid = string_valid_q;

endmodule
`default_nettype wire
